>>> rtl/kdz_rtp_pkg.sv
// Shared types, constants and a helper function of the record table parser.
`timescale 1ns / 1ps

package kdz_rtp_pkg;

  localparam int NAME_BYTES_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int RESULT_DEPTH_DEF = 2;
  localparam int MAGIC_LEN       = 8;
  localparam int FIELD_TAIL      = 16;
  localparam int SIZE_W          = 40;
  localparam int LO_BYTES        = SIZE_W / 8;
  localparam int INDEX_W         = 12;

  localparam logic [7:0] MARK_LAST = 8'h03;
  localparam logic [7:0] MARK_END  = 8'h00;

  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_TABLE  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MAGIC = 3'd1;
  localparam logic [2:0] ERR_NUL   = 3'd2;
  localparam logic [2:0] ERR_RANGE = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_SKIP,
    PH_REC,
    PH_MARK,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_MAGIC,
    ACT_SKIP,
    ACT_LAST,
    ACT_NAME,
    ACT_NUL,
    ACT_LEN,
    ACT_OFF,
    ACT_RECORD,
    ACT_TABLE_END,
    ACT_ERR_MAGIC,
    ACT_ERR_EMPTY,
    ACT_ERR_NUL,
    ACT_ERR_RANGE
  } action_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_item_t;

  // A byte as the front end hands it to the engine, with its position checks done.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
    logic       first;
    logic       too_short;
    logic       magic_ok;
    logic       magic_last;
    logic       fits_next;
    logic       fits_after;
    logic       at_end;
  } byte_class_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [7:0]         name_byte;
    logic [INDEX_W-1:0] record_index;
    logic [SIZE_W-1:0]  record_length;
    logic [SIZE_W-1:0]  record_offset;
    logic               table_done;
    logic [2:0]         error_code;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h28;
      3'd1: val = 8'h05;
      3'd2: val = 8'h00;
      3'd3: val = 8'h00;
      3'd4: val = 8'h24;
      3'd5: val = 8'h38;
      3'd6: val = 8'h22;
      3'd7: val = 8'h25;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/kdz_rtp_fifo.sv
// Small synchronous queue built from registers.
`timescale 1ns / 1ps

module kdz_rtp_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/kdz_rtp_front.sv
// Front end: tracks the byte position and classifies each incoming byte.
`timescale 1ns / 1ps

module kdz_rtp_front
  import kdz_rtp_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] file_size,
  input  in_item_t          item,
  input  logic              accept,
  output byte_class_t       cls
);

  localparam int REC_BYTES = NAME_BYTES + FIELD_TAIL;

  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] pos_cur;
  logic [SIZE_W:0]   pos_ext;
  logic [SIZE_W:0]   size_ext;

  assign pos_cur  = item.start_of_file ? '0 : pos;
  assign pos_ext  = {1'b0, pos_cur};
  assign size_ext = {1'b0, file_size};

  always_comb begin
    cls.byte_value    = item.byte_value;
    cls.start_of_file = item.start_of_file;
    cls.first         = (pos_cur == '0);
    cls.too_short     = (file_size < SIZE_W'(MAGIC_LEN + REC_BYTES));
    cls.magic_ok      = (pos_cur < SIZE_W'(MAGIC_LEN)) &&
                        (item.byte_value == magic_byte(pos_cur[2:0]));
    cls.magic_last    = (pos_cur == SIZE_W'(MAGIC_LEN - 1));
    cls.fits_next     = (pos_ext + (SIZE_W + 1)'(REC_BYTES)) <= size_ext;
    cls.fits_after    = (pos_ext + (SIZE_W + 1)'(REC_BYTES + 1)) <= size_ext;
    cls.at_end        = (pos_ext + (SIZE_W + 1)'(1)) >= size_ext;
  end

  // The position wraps at the width of the file size.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_cur + SIZE_W'(1);
    end
  end

endmodule

>>> rtl/kdz_rtp_engine.sv
// Back end: the table parsing state machine that turns classified bytes into results.
`timescale 1ns / 1ps

module kdz_rtp_engine
  import kdz_rtp_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] file_size,
  input  logic              q_empty,
  input  byte_class_t       q_data,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output result_t           res_data
);

  localparam int REC_BYTES = NAME_BYTES + FIELD_TAIL;
  localparam int CNT_W     = $clog2(REC_BYTES + 1);
  localparam logic [CNT_W-1:0] NAME_K = CNT_W'(NAME_BYTES);
  localparam logic [CNT_W-1:0] OFF_K  = CNT_W'(NAME_BYTES + 8);
  localparam logic [CNT_W-1:0] LAST_K = CNT_W'(REC_BYTES - 1);

  phase_t             phase;
  phase_t             phase_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               nul_seen;
  logic               nul_seen_next;
  logic               last_pending;
  logic               last_pending_next;
  logic [INDEX_W-1:0] records_seen;
  logic [INDEX_W-1:0] records_seen_next;

  logic [SIZE_W-1:0]  len_lo;
  logic [SIZE_W-1:0]  len_lo_next;
  logic               len_hi_nz;
  logic               len_hi_nz_next;
  logic [SIZE_W-1:0]  off_lo;
  logic [SIZE_W-1:0]  off_lo_next;
  logic               off_hi_nz;
  logic               off_hi_nz_next;
  logic [SIZE_W:0]    rem;
  logic [SIZE_W:0]    rem_next;
  logic               len_gt;
  logic               len_gt_next;

  logic               advance;
  logic               sof;
  logic [7:0]         b;
  phase_t             ph;
  logic [CNT_W-1:0]   k;
  logic               nul_eff;
  logic               last_eff;
  logic [INDEX_W-1:0] recs_eff;
  logic [2:0]         len_lane;
  logic [2:0]         off_lane;
  logic               range_err;
  logic               done;
  action_t            rec_act;
  action_t            act;
  logic               emit;

  assign advance = !q_empty && !res_full;
  assign q_pop   = advance;
  assign res_push = advance && emit;

  // A start of file clears the phase, field count, NUL flag, last-record flag and record count before the byte is used.
  assign sof      = q_data.start_of_file;
  assign b        = q_data.byte_value;
  assign ph       = sof ? PH_MAGIC : phase;
  assign k        = (ph == PH_REC) ? cnt : '0;
  assign nul_eff  = (k == '0) ? 1'b0 : nul_seen;
  assign last_eff = sof ? 1'b0 : last_pending;
  assign recs_eff = sof ? '0 : records_seen;
  assign len_lane = 3'(k - NAME_K);
  assign off_lane = 3'(k - OFF_K);
  assign done     = last_eff || q_data.at_end;

  // The final offset byte only adds the top bits, so the range test is mostly precomputed.
  assign range_err = off_hi_nz || (b != 8'h00) || len_gt;

  always_comb begin
    if (k < NAME_K) begin
      if (b == 8'h00) begin
        rec_act = ACT_NUL;
      end else if (nul_eff) begin
        rec_act = ACT_ERR_NUL;
      end else begin
        rec_act = ACT_NAME;
      end
    end else if (k < OFF_K) begin
      rec_act = ACT_LEN;
    end else if (k != LAST_K) begin
      rec_act = ACT_OFF;
    end else if (range_err) begin
      rec_act = ACT_ERR_RANGE;
    end else begin
      rec_act = ACT_RECORD;
    end
  end

  always_comb begin
    case (ph)
      PH_MAGIC: begin
        if ((q_data.first && q_data.too_short) || !q_data.magic_ok) begin
          act = ACT_ERR_MAGIC;
        end else begin
          act = ACT_MAGIC;
        end
      end
      PH_SKIP: begin
        if (b == MARK_LAST) begin
          act = q_data.fits_after ? ACT_SKIP : ACT_ERR_EMPTY;
        end else begin
          act = rec_act;
        end
      end
      PH_REC: begin
        act = rec_act;
      end
      PH_MARK: begin
        if (b == MARK_END) begin
          act = ACT_TABLE_END;
        end else if (b == MARK_LAST) begin
          act = q_data.fits_after ? ACT_LAST : ACT_TABLE_END;
        end else begin
          act = q_data.fits_next ? rec_act : ACT_TABLE_END;
        end
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    case (act)
      ACT_MAGIC:     phase_next = q_data.magic_last ? PH_SKIP : PH_MAGIC;
      ACT_SKIP,
      ACT_LAST,
      ACT_NAME,
      ACT_NUL,
      ACT_LEN,
      ACT_OFF:       phase_next = PH_REC;
      ACT_RECORD:    phase_next = done ? PH_DONE : PH_MARK;
      ACT_TABLE_END: phase_next = PH_DONE;
      ACT_ERR_MAGIC,
      ACT_ERR_EMPTY,
      ACT_ERR_NUL,
      ACT_ERR_RANGE: phase_next = PH_ERR;
      default:       phase_next = ph;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    cnt_next          = k;
    nul_seen_next     = nul_eff;
    last_pending_next = last_eff;
    records_seen_next = recs_eff;
    len_lo_next       = len_lo;
    len_hi_nz_next    = len_hi_nz;
    off_lo_next       = off_lo;
    off_hi_nz_next    = off_hi_nz;
    rem_next          = rem;
    len_gt_next       = len_gt;

    emit                  = 1'b0;
    res_data.result_kind  = KIND_NAME;
    res_data.name_byte    = 8'h00;
    res_data.record_index = recs_eff;
    res_data.record_length = '0;
    res_data.record_offset = '0;
    res_data.table_done   = 1'b0;
    res_data.error_code   = ERR_NONE;

    if (act == ACT_NAME || act == ACT_NUL || act == ACT_ERR_NUL) begin
      if (k == '0) begin
        len_lo_next    = '0;
        len_hi_nz_next = 1'b0;
        off_lo_next    = '0;
        off_hi_nz_next = 1'b0;
      end
    end

    case (act)
      ACT_NAME: begin
        cnt_next           = k + CNT_W'(1);
        emit               = 1'b1;
        res_data.name_byte = b;
      end
      ACT_NUL: begin
        cnt_next      = k + CNT_W'(1);
        nul_seen_next = 1'b1;
      end
      ACT_LEN: begin
        cnt_next = k + CNT_W'(1);
        for (int i = 0; i < LO_BYTES; i++) begin
          if (len_lane == 3'(i)) begin
            len_lo_next[8*i +: 8] = b;
          end
        end
        if (len_lane >= 3'(LO_BYTES) && b != 8'h00) begin
          len_hi_nz_next = 1'b1;
        end
      end
      ACT_OFF: begin
        cnt_next = k + CNT_W'(1);
        for (int i = 0; i < LO_BYTES; i++) begin
          if (off_lane == 3'(i)) begin
            off_lo_next[8*i +: 8] = b;
          end
        end
        if (off_lane >= 3'(LO_BYTES) && b != 8'h00) begin
          off_hi_nz_next = 1'b1;
        end
        // Low offset bytes are complete here; the borrow flags offset above the size.
        if (off_lane == 3'(LO_BYTES)) begin
          rem_next = {1'b0, file_size} - {1'b0, off_lo};
        end
        if (off_lane == 3'(LO_BYTES + 1)) begin
          len_gt_next = len_hi_nz || rem[SIZE_W] || (len_lo > rem[SIZE_W-1:0]);
        end
      end
      ACT_RECORD: begin
        cnt_next               = '0;
        records_seen_next      = recs_eff + INDEX_W'(1);
        emit                   = 1'b1;
        res_data.result_kind   = KIND_RECORD;
        res_data.record_length = len_lo;
        res_data.record_offset = off_lo;
        res_data.table_done    = done;
      end
      ACT_SKIP: begin
        cnt_next = '0;
      end
      ACT_LAST: begin
        cnt_next          = '0;
        last_pending_next = 1'b1;
      end
      ACT_TABLE_END: begin
        cnt_next             = '0;
        emit                 = 1'b1;
        res_data.result_kind = KIND_TABLE;
      end
      ACT_ERR_MAGIC: begin
        emit                 = 1'b1;
        res_data.result_kind = KIND_ERROR;
        res_data.error_code  = ERR_MAGIC;
      end
      ACT_ERR_EMPTY: begin
        emit                 = 1'b1;
        res_data.result_kind = KIND_ERROR;
        res_data.error_code  = ERR_EMPTY;
      end
      ACT_ERR_NUL: begin
        emit                 = 1'b1;
        res_data.result_kind = KIND_ERROR;
        res_data.error_code  = ERR_NUL;
      end
      ACT_ERR_RANGE: begin
        emit                 = 1'b1;
        res_data.result_kind = KIND_ERROR;
        res_data.error_code  = ERR_RANGE;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC;
      cnt          <= '0;
      nul_seen     <= 1'b0;
      last_pending <= 1'b0;
      records_seen <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      nul_seen     <= nul_seen_next;
      last_pending <= last_pending_next;
      records_seen <= records_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_lo    <= len_lo_next;
      len_hi_nz <= len_hi_nz_next;
      off_lo    <= off_lo_next;
      off_hi_nz <= off_hi_nz_next;
      rem       <= rem_next;
      len_gt    <= len_gt_next;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_record_clears_count: assert property (@(posedge clk) disable iff (rst)
    (advance && act == ACT_RECORD) |=> (cnt == '0))
    else $error("field count not cleared after a completed record");

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && !sof && (phase == PH_DONE || phase == PH_ERR)) |-> !res_push)
    else $error("result produced after the table ended");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.result_kind == KIND_ERROR) |=> (phase == PH_ERR))
    else $error("parser did not stop after an error");

endmodule

>>> rtl/kdz_record_table_parser_top.sv
// Top level of the record table parser: size register, front end, queues and engine.
// A byte's result reaches the result ports through the byte queue, engine and result queue.
// Throughput: one byte per cycle if results have room; one phase step and compare per byte.
// The size compares run in the front end and the range test is spread over the offset bytes.
// Reset (rst, synchronous): queues empty, parser back to the magic check, file size zero.
`timescale 1ns / 1ps

module kdz_record_table_parser_top
  import kdz_rtp_pkg::*;
#(
  parameter int NAME_BYTES   = NAME_BYTES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              push,
  input  in_item_t          byte_item,
  output logic              full,
  input  logic              pop,
  output result_t           result,
  output logic              empty
);

  localparam int CLASS_W  = $bits(byte_class_t);
  localparam int RESULT_W = $bits(result_t);

  logic [SIZE_W-1:0] file_size;
  logic              accept;
  byte_class_t       cls;
  logic [CLASS_W-1:0] q_rdata;
  logic              q_empty;
  logic              q_pop;
  logic              res_full;
  logic              res_push;
  result_t           res_data;
  logic [RESULT_W-1:0] res_rdata;

  assign accept = push && !full;
  assign result = result_t'(res_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_wr_en) begin
      file_size <= cfg_wr_data;
    end
  end

  kdz_rtp_front #(
    .NAME_BYTES (NAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .file_size (file_size),
    .item      (byte_item),
    .accept    (accept),
    .cls       (cls)
  );

  kdz_rtp_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CLASS_W)
  ) u_byte_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  kdz_rtp_engine #(
    .NAME_BYTES (NAME_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .file_size (file_size),
    .q_empty   (q_empty),
    .q_data    (byte_class_t'(q_rdata)),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  kdz_rtp_fifo #(
    .DEPTH (RESULT_DEPTH),
    .WIDTH (RESULT_W)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the record table parser: random container files against a parse model.
`timescale 1ns / 1ps

module tb;
  import kdz_rtp_pkg::*;

  // The name field has the block's default width.
  localparam int NAME_LEN = NAME_BYTES_DEF;
  localparam int REC_LEN = NAME_LEN + FIELD_TAIL;
  localparam int MIN_FILE = MAGIC_LEN + REC_LEN;
  localparam logic [63:0] FILE_MAGIC = 64'h2522_3824_0000_0528;
  localparam longint unsigned SIZE_MASK = 64'h00FF_FFFF_FFFF;
  localparam logic [7:0] NUL = 8'h00;
  localparam int unsigned ITEMS = 1650;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned LIMIT = 400000;

  class table_walker;
    longint unsigned    size_reg;
    phase_t             ph;
    longint unsigned    pos;
    int unsigned        fld;
    bit                 nul_seen;
    bit                 last_pend;
    logic [63:0]        len_acc;
    logic [63:0]        off_acc;
    logic [INDEX_W-1:0] done_recs;
    result_t            parse_results[$];
    int unsigned        faults;
    int unsigned        tally[4];

    function new();
      size_reg = 0;
      faults = 0;
      restart();
    endfunction

    function void restart();
      ph = PH_MAGIC;
      pos = 0;
      fld = 0;
      nul_seen = 1'b0;
      last_pend = 1'b0;
      len_acc = '0;
      off_acc = '0;
      done_recs = '0;
    endfunction

    function bit give(output result_t r, input logic [1:0] kind, input logic [7:0] nb,
                      input logic [63:0] len, input logic [63:0] off, input bit fin,
                      input logic [2:0] code);
      r.result_kind = kind;
      r.name_byte = nb;
      r.record_index = done_recs;
      r.record_length = len[SIZE_W-1:0];
      r.record_offset = off[SIZE_W-1:0];
      r.table_done = fin;
      r.error_code = code;
      return 1'b1;
    endfunction

    function bit abort(output result_t r, input logic [2:0] code);
      ph = PH_ERR;
      return give(r, KIND_ERROR, NUL, '0, '0, 1'b0, code);
    endfunction

    function bit record_byte(input logic [7:0] b, input longint unsigned at,
                             output result_t r);
      int unsigned k;
      bit fin;
      r = '0;
      k = fld;
      if (k == 0) begin
        nul_seen = 1'b0;
        len_acc = '0;
        off_acc = '0;
      end
      ph = PH_REC;
      fld = k + 1;
      if (k < NAME_LEN) begin
        if (b == NUL) begin
          nul_seen = 1'b1;
          return 1'b0;
        end
        if (nul_seen) return abort(r, ERR_NUL);
        return give(r, KIND_NAME, b, '0, '0, 1'b0, ERR_NONE);
      end
      if (k < NAME_LEN + 8) begin
        len_acc |= {56'd0, b} << (8 * (k - NAME_LEN));
        return 1'b0;
      end
      off_acc |= {56'd0, b} << (8 * ((k - NAME_LEN - 8) & 7));
      if (k + 1 < REC_LEN) return 1'b0;
      if (off_acc > size_reg || len_acc > size_reg - off_acc) return abort(r, ERR_RANGE);
      // The table also ends when the record reaches the end of the file.
      fin = last_pend || (at + 1 >= size_reg);
      void'(give(r, KIND_RECORD, NUL, len_acc, off_acc, fin, ERR_NONE));
      done_recs++;
      fld = 0;
      ph = fin ? PH_DONE : PH_MARK;
      return 1'b1;
    endfunction

    function bit step(input in_item_t it, output result_t r);
      longint unsigned at;
      logic [7:0] b;
      r = '0;
      b = it.byte_value;
      if (it.start_of_file) restart();
      at = pos;
      pos = (pos + 1) & SIZE_MASK;
      case (ph)
        PH_MAGIC: begin
          if (at == 0 && size_reg < MIN_FILE) return abort(r, ERR_MAGIC);
          if (at >= MAGIC_LEN) return abort(r, ERR_MAGIC);
          if (b != FILE_MAGIC[8*int'(at) +: 8]) return abort(r, ERR_MAGIC);
          if (at == MAGIC_LEN - 1) ph = PH_SKIP;
          return 1'b0;
        end
        PH_SKIP: begin
          fld = 0;
          if (b == MARK_LAST) begin
            if (at + 1 + REC_LEN > size_reg) return abort(r, ERR_EMPTY);
            ph = PH_REC;
            return 1'b0;
          end
          return record_byte(b, at, r);
        end
        PH_REC: return record_byte(b, at, r);
        PH_MARK: begin
          fld = 0;
          // An end marker, or a next record that cannot fit, closes the table here.
          if (b == MARK_END || (b == MARK_LAST && at + 1 + REC_LEN > size_reg) ||
              (b != MARK_LAST && at + REC_LEN > size_reg)) begin
            ph = PH_DONE;
            return give(r, KIND_TABLE, NUL, '0, '0, 1'b0, ERR_NONE);
          end
          if (b == MARK_LAST) begin
            last_pend = 1'b1;
            ph = PH_REC;
            return 1'b0;
          end
          return record_byte(b, at, r);
        end
        default: return 1'b0;
      endcase
    endfunction

    function void take_byte(input in_item_t it);
      result_t r;
      if (step(it, r)) parse_results.push_back(r);
    endfunction

    function void cmp(input string field, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        faults++;
      end
    endfunction

    function void match_result(input result_t got);
      result_t want;
      if (parse_results.size() == 0) begin
        $error("result with none outstanding: kind %0d, index %0d",
               got.result_kind, got.record_index);
        faults++;
        return;
      end
      want = parse_results.pop_front();
      tally[want.result_kind]++;
      cmp("result_kind", want.result_kind, got.result_kind);
      cmp("name_byte", want.name_byte, got.name_byte);
      cmp("record_index", want.record_index, got.record_index);
      cmp("record_length", want.record_length, got.record_length);
      cmp("record_offset", want.record_offset, got.record_offset);
      cmp("table_done", want.table_done, got.table_done);
      cmp("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;
  logic              push;
  in_item_t          byte_item;
  logic              full;
  logic              pop;
  result_t           result;
  logic              empty;

  table_walker  walker;
  logic [7:0]   img[$];
  bit           calm = 1'b0;
  int unsigned  sent = 0;
  int unsigned  files = 0;
  int unsigned  settings = 0;
  int unsigned  cycles = 0;

  kdz_record_table_parser_top #(.NAME_BYTES(NAME_LEN)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push       (push),
    .byte_item  (byte_item),
    .full       (full),
    .pop        (pop),
    .result     (result),
    .empty      (empty)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t item(input logic [7:0] b, input bit sof);
    in_item_t it;
    it.byte_value = b;
    it.start_of_file = sof;
    return it;
  endfunction

  function automatic void put_u64(input logic [63:0] v);
    for (int i = 0; i < 8; i++) img.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_record(input longint unsigned span, input bit nul_flaw,
                                     input bit range_flaw);
    int unsigned used;
    int unsigned base;
    logic [63:0] off;
    logic [63:0] len;
    base = img.size();
    used = ($urandom_range(3) == 0) ? NAME_LEN : $urandom_range(NAME_LEN, 1);
    // The first name byte must not read as a marker when the record follows directly.
    img.push_back(8'($urandom_range(255, 4)));
    for (int i = 1; i < NAME_LEN; i++) img.push_back(i < used ? 8'($urandom_range(255, 1)) : NUL);
    if (nul_flaw && used + 1 < NAME_LEN)
      img[base + $urandom_range(NAME_LEN - 1, used + 1)] = 8'($urandom_range(255, 1));
    case ($urandom_range(3))
      0: off = 0;
      1: off = span;
      default: off = rand64() % (span + 1);
    endcase
    case ($urandom_range(3))
      0: len = 0;
      1: len = span - off;
      default: len = rand64() % (span - off + 1);
    endcase
    if (range_flaw) begin
      case ($urandom_range(2))
        0: off = span + 1;
        1: len = span - off + 1;
        default: off[63] = 1'b1;
      endcase
    end
    put_u64(len);
    put_u64(off);
  endfunction

  // Builds one container image in img; returns 1 when it is loose noise.
  function automatic bit build_file(input longint unsigned span, input bit flaws);
    int unsigned nrec;
    int unsigned cut;
    img.delete();
    if (flaws && $urandom_range(9) == 0) begin
      repeat ($urandom_range(40, 1)) img.push_back(8'($urandom));
      return 1'b1;
    end
    for (int i = 0; i < MAGIC_LEN; i++) img.push_back(FILE_MAGIC[8*i +: 8]);
    if (flaws && $urandom_range(7) == 0)
      img[$urandom_range(MAGIC_LEN - 1)] ^= 8'(1 << $urandom_range(7));
    if ($urandom_range(1)) img.push_back(MARK_LAST);
    nrec = $urandom_range(4, 1);
    for (int r = 0; r < nrec; r++) begin
      if (r > 0 && r == nrec - 1 && $urandom_range(1)) img.push_back(MARK_LAST);
      put_record(span, flaws && $urandom_range(11) == 0, flaws && $urandom_range(11) == 0);
    end
    if ($urandom_range(2) != 0) img.push_back(MARK_END);
    if (flaws && $urandom_range(5) == 0)
      repeat ($urandom_range(6, 1)) img.push_back(8'($urandom));
    if (flaws && $urandom_range(7) == 0) begin
      cut = $urandom_range(img.size() - 1, 1);
      while (img.size() > cut) void'(img.pop_back());
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input in_item_t it);
    while (!calm && $urandom_range(99) < 16) begin
      push <= 1'b0;
      byte_item <= {8'($urandom), 1'($urandom)};
      @(posedge clk);
    end
    push <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_file(input bit loose);
    for (int i = 0; i < img.size(); i++) begin
      // The run stops at its item budget, even part way through a file.
      if (sent >= ITEMS) break;
      send_byte(item(img[i], loose ? ($urandom_range(15) == 0) : (i == 0)));
    end
    files++;
  endtask

  // The size register only changes once the parser has gone quiet.
  task automatic set_size(input longint unsigned v);
    push <= 1'b0;
    @(posedge clk);
    while (walker.parse_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= SIZE_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    walker.size_reg = v & SIZE_MASK;
    settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      pop <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) walker.take_byte(byte_item);
      if (pop && !empty) walker.match_result(result);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("kdz_record_table_parser_top: mismatch");
      $finish;
    end
  end

  initial begin
    bit loose;
    longint unsigned span;
    walker = new();
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    push <= 1'b0;
    byte_item <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A zero size fails at once, even for bytes sent before any start of file.
    set_size(0);
    send_byte(item(8'h28, 1'b0));
    send_byte(item(8'hFF, 1'b0));
    send_byte(item(NUL, 1'b1));
    // Largest size: skip marker, a name byte, then a non-NUL after a NUL.
    set_size(SIZE_MASK);
    for (int i = 0; i < MAGIC_LEN; i++) send_byte(item(FILE_MAGIC[8*i +: 8], i == 0));
    send_byte(item(MARK_LAST, 1'b0));
    send_byte(item(8'hFF, 1'b0));
    send_byte(item(NUL, 1'b0));
    send_byte(item(8'h7E, 1'b0));
    send_byte(item(8'h80, 1'b0));
    // Smallest legal size with a skip marker leaves no room for a record.
    set_size(MIN_FILE);
    for (int i = 0; i < MAGIC_LEN; i++) send_byte(item(FILE_MAGIC[8*i +: 8], i == 0));
    send_byte(item(MARK_LAST, 1'b0));

    while (sent < ITEMS) begin
      calm = sent >= 700 && sent < 1000;
      case ($urandom_range(9))
        0: begin
          set_size(0);
          loose = build_file(MIN_FILE, 1'b1);
          send_file(loose);
        end
        1, 2: begin
          set_size(SIZE_MASK);
          repeat (2) begin
            loose = build_file(SIZE_MASK, 1'b1);
            send_file(loose);
          end
        end
        3, 4, 5: begin
          // Size set around the image length, so tables end by size.
          loose = build_file(MIN_FILE, 1'b1);
          set_size(img.size() + $urandom_range(2) - 1);
          send_file(loose);
        end
        6, 7: begin
          span = $urandom_range(400, MIN_FILE - 2);
          set_size(span);
          repeat (2) begin
            loose = build_file(span, 1'b1);
            send_file(loose);
          end
        end
        default: begin
          span = rand64() & SIZE_MASK;
          set_size(span);
          repeat (2) begin
            loose = build_file(span, 1'b1);
            send_file(loose);
          end
        end
      endcase
    end
    calm = 1'b0;

    push <= 1'b0;
    @(posedge clk);
    while (walker.parse_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d bytes in %0d files under %0d size settings, with gaps on both sides.",
             sent, files, settings);
    $display("Checked %0d name bytes, %0d records, %0d table ends and %0d errors.",
             walker.tally[KIND_NAME], walker.tally[KIND_RECORD], walker.tally[KIND_TABLE],
             walker.tally[KIND_ERROR]);
    if (walker.faults == 0) begin
      $display("kdz_record_table_parser_top: match");
    end else begin
      $display("kdz_record_table_parser_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/kdz_rtp_pkg.sv
rtl/kdz_rtp_fifo.sv
rtl/kdz_rtp_front.sv
rtl/kdz_rtp_engine.sv
rtl/kdz_record_table_parser_top.sv
verif/tb.sv
